@@ rtl/sps_pkg.sv @@
// Shared types, constants and the compare-time function of the servo pulse sequencer.
// Used by the top level, the compare table and the port checker. No dependencies.
package sps_pkg;

  localparam int BLOCK_COUNT = 12;
  localparam int BLK_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int PIN_W       = 5;
  localparam int CMP_W       = 16;

  localparam int GAP_TICKS   = 36;
  localparam int ZERO_OFFSET = 255 + GAP_TICKS;
  localparam int FRAME_TICKS = ZERO_OFFSET + 255 + (GAP_TICKS / 2);
  localparam int TICK_MAX    = 32'h0000_ffff;
  localparam int TICK_SCALE  = 8;
  localparam int TICK_SHIFT  = $clog2(TICK_SCALE);
  localparam int MIN_COMPARE = 5;

  // tick counts of the three stored times, before the position is applied
  localparam int BON_TICKS   = GAP_TICKS + FRAME_TICKS - ZERO_OFFSET;
  localparam int AOFF_TICKS  = GAP_TICKS + ZERO_OFFSET;
  localparam int FIN_TICKS   = GAP_TICKS + FRAME_TICKS;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_EVENT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [CMP_W-1:0] fin;
    logic [CMP_W-1:0] aoff;
    logic [CMP_W-1:0] bon;
  } cmp_entry_t;

  typedef struct packed {
    logic             en;
    logic [BLK_W-1:0] addr;
    cmp_entry_t       data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [BLK_W-1:0] addr;
  } tbl_rd_t;

  // ticks -> compare value: floor of one tick, x8 with saturation, add base,
  // wrap by TICK_MAX on overflow, floor of MIN_COMPARE
  function automatic logic [CMP_W-1:0] tick_to_cmp(input logic [CMP_W-1:0] ticks,
                                                   input logic [CMP_W-1:0] base);
    logic [CMP_W-1:0] t1;
    logic [CMP_W-1:0] v;
    logic [CMP_W:0]   sum;
    t1 = (ticks <= CMP_W'(1)) ? CMP_W'(1) : ticks;
    if (t1 > CMP_W'(TICK_MAX / TICK_SCALE)) v = CMP_W'(TICK_MAX);
    else v = t1 << TICK_SHIFT;
    sum = {1'b0, v} + {1'b0, base};
    if (sum > (CMP_W+1)'(TICK_MAX)) sum = sum - (CMP_W+1)'(TICK_MAX);
    if (sum < (CMP_W+1)'(MIN_COMPARE)) return CMP_W'(MIN_COMPARE);
    return sum[CMP_W-1:0];
  endfunction

endpackage

@@ rtl/sps_cmp_table.sv @@
// Per-block compare table: one entry of three compare times per block, registered read.
// Valid bits make unwritten entries read as zero. Depends on sps_pkg.
module sps_cmp_table (
  input  logic               clk,
  input  logic               rst_n,
  input  sps_pkg::tbl_wr_t   wr,
  input  sps_pkg::tbl_rd_t   rd,
  output sps_pkg::cmp_entry_t rd_data
);
  import sps_pkg::*;

  cmp_entry_t             mem [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] vld_r;
  cmp_entry_t             rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ rtl/servo_pulse_sequencer.sv @@
// Top level of the servo pulse sequencer: phase control, compare table and output register.
// Depends on sps_pkg and sps_cmp_table.
//
// Usage:
//   in_*  : one transfer per command. in_tuser is the command (start or compare event),
//           in_tdata carries the start timer count and the next block's positions.
//   out_* : exactly one result transfer per command: next compare value and the pin
//           action (pin, level, timer restart).
//   Path: a command goes through the table-read stage, then the output register,
//   before out_tvalid rises. Throughput: one command per cycle while out_tready is
//   high, set by the single read-or-write access per cycle to the compare table;
//   a finish writes the next block's entry at the edge it is taken, so the following
//   command reads it back.
//   Reset: phase and block index to zero, table entries read as zero until the
//   finish phase of their block writes them. No clearing pass.
//   Stall: while out_tready is low the output register holds; one more command is
//   still taken into the table-read stage, after which in_tready drops.
module servo_pulse_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // timer_now[15:0], position_a[23:16], position_b[31:24],
                                  // servo_mode_a[32], servo_mode_b[33], zero pad
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // compare_value[15:0], pin_valid[16], pin_number[21:17],
                                  // pin_level[22], timer_restart[23]
);
  import sps_pkg::*;

  typedef enum logic [1:0] {
    PH_A_ON   = 2'd0,
    PH_B_ON   = 2'd1,
    PH_A_OFF  = 2'd2,
    PH_FINISH = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_BON,
    SRC_AOFF,
    SRC_FIN
  } src_t;

  phase_t           phase_r, phase_nxt;
  logic [BLK_W-1:0] block_r, block_nxt, block_inc;
  logic             s1_valid_r, out_valid_r;
  logic             accept, s1_adv;

  // stage 1 payload
  src_t             s1_src_r, src_nxt;
  logic [CMP_W-1:0] s1_cmp_r, cmp_nxt;
  logic             s1_pin_valid_r, pin_valid_nxt;
  logic [PIN_W-1:0] s1_pin_r, pin_nxt;
  logic             s1_level_r, level_nxt;
  logic             s1_restart_r, restart_nxt;

  logic [23:0]      out_tdata_r;
  logic [CMP_W-1:0] s1_cmp_sel;

  tbl_wr_t          tbl_wr;
  tbl_rd_t          tbl_rd;
  cmp_entry_t       tbl_rd_data;

  logic [CMP_W-1:0] timer_now;
  logic [7:0]       pos_a, pos_b;
  cmd_t             cmd;

  assign timer_now = in_tdata[15:0];
  assign pos_a     = in_tdata[32] ? in_tdata[23:16] : 8'd0;
  assign pos_b     = in_tdata[33] ? in_tdata[31:24] : 8'd0;
  assign cmd       = cmd_t'(in_tuser);

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  assign block_inc = (block_r >= BLK_W'(BLOCK_COUNT - 1)) ? '0 : block_r + BLK_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    block_nxt     = block_r;
    src_nxt       = SRC_DIRECT;
    cmp_nxt       = '0;
    pin_valid_nxt = 1'b0;
    pin_nxt       = '0;
    level_nxt     = 1'b0;
    restart_nxt   = 1'b0;
    tbl_rd.en     = 1'b0;
    tbl_rd.addr   = block_r;
    tbl_wr.en     = 1'b0;
    tbl_wr.addr   = block_inc;
    // finish always runs with a timer base of zero
    tbl_wr.data.bon  = tick_to_cmp(CMP_W'(BON_TICKS) - {8'd0, pos_b}, '0);
    tbl_wr.data.aoff = tick_to_cmp(CMP_W'(AOFF_TICKS) + {8'd0, pos_a}, '0);
    tbl_wr.data.fin  = tick_to_cmp(CMP_W'(FIN_TICKS), '0);
    if (cmd == CMD_START) begin
      phase_nxt = PH_A_ON;
      block_nxt = '0;
      cmp_nxt   = tick_to_cmp(CMP_W'(GAP_TICKS), timer_now);
    end else begin
      pin_valid_nxt = 1'b1;
      case (phase_r)
        PH_A_ON: begin
          pin_nxt   = PIN_W'(block_r);
          level_nxt = 1'b1;
          src_nxt   = SRC_BON;
          tbl_rd.en = accept;
          phase_nxt = PH_B_ON;
        end
        PH_B_ON: begin
          pin_nxt   = PIN_W'(block_r) + PIN_W'(BLOCK_COUNT);
          level_nxt = 1'b1;
          src_nxt   = SRC_AOFF;
          tbl_rd.en = accept;
          phase_nxt = PH_A_OFF;
        end
        PH_A_OFF: begin
          pin_nxt   = PIN_W'(block_r);
          src_nxt   = SRC_FIN;
          tbl_rd.en = accept;
          phase_nxt = PH_FINISH;
        end
        default: begin
          pin_nxt     = PIN_W'(block_r) + PIN_W'(BLOCK_COUNT);
          restart_nxt = 1'b1;
          cmp_nxt     = tick_to_cmp(CMP_W'(GAP_TICKS), '0);
          tbl_wr.en   = accept;
          block_nxt   = block_inc;
          phase_nxt   = PH_A_ON;
        end
      endcase
    end
  end

  sps_cmp_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_A_ON;
      block_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        block_r <= block_nxt;
      end
      if (accept) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r       <= src_nxt;
      s1_cmp_r       <= cmp_nxt;
      s1_pin_valid_r <= pin_valid_nxt;
      s1_pin_r       <= pin_nxt;
      s1_level_r     <= level_nxt;
      s1_restart_r   <= restart_nxt;
    end
    if (s1_valid_r && s1_adv) begin
      out_tdata_r <= {s1_restart_r, s1_level_r, s1_pin_r, s1_pin_valid_r, s1_cmp_sel};
    end
  end

  always_comb begin
    case (s1_src_r)
      SRC_BON:  s1_cmp_sel = tbl_rd_data.bon;
      SRC_AOFF: s1_cmp_sel = tbl_rd_data.aoff;
      SRC_FIN:  s1_cmp_sel = tbl_rd_data.fin;
      default:  s1_cmp_sel = s1_cmp_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/sps_checker.sv @@
// Port checker for the servo pulse sequencer, bound to the top level.
// Depends on sps_pkg.
module sps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import sps_pkg::*;

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no pin action: pin, level and restart are all clear
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[23:17] == 7'd0)
    else $error("pin fields set without a pin action");

  // restart only on the B-off of a finish, with the gap compare
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23] |->
      out_tdata[16] && !out_tdata[22] && out_tdata[21:17] >= PIN_W'(BLOCK_COUNT)
      && out_tdata[15:0] == tick_to_cmp(CMP_W'(GAP_TICKS), '0))
    else $error("bad finish result");

  a_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[21:17] < PIN_W'(2 * BLOCK_COUNT))
    else $error("pin number out of range");

endmodule

bind servo_pulse_sequencer sps_checker u_sps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
